>>> hdl/elastic_circle_collision_response_unit_macros.svh
// Assertion macros used by the checker file of the collision unit.
`ifndef ELASTIC_CIRCLE_COLLISION_RESPONSE_UNIT_MACROS_SVH
`define ELASTIC_CIRCLE_COLLISION_RESPONSE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst is high.
`define ECC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("collision unit check failed");

// Next-cycle implication, sampled on clk, always active.
`define ECC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("collision unit check failed");

`endif

>>> hdl/ecc_pkg.sv
// Shared widths, stage indexes and types of the collision unit.
package ecc_pkg;

  localparam int VelW  = 24;
  localparam int QuoW  = 26;   // quotient bound: |q| < 2 * |dv| < 2^26
  localparam int NumW  = 90;   // 2*m * |dot| * |d.c|
  localparam int DenW  = 66;   // |d|^2 * (mass_i + mass_j)
  localparam int Lanes = 4;

  localparam int DivFirst = 6;
  localparam int OutStage = DivFirst + QuoW;
  localparam int NumStages = OutStage + 1;

  typedef struct packed {
    logic signed [VelW-1:0] vel_i_x;
    logic signed [VelW-1:0] vel_i_y;
    logic signed [VelW-1:0] vel_j_x;
    logic signed [VelW-1:0] vel_j_y;
    logic                   touch;
    logic                   hit;
    logic                   degen;
    logic                   apply;
    logic                   neg_x;
    logic                   neg_y;
  } side_t;

endpackage

>>> hdl/elastic_circle_collision_response_unit.sv
// Top level of the elastic circle collision velocity update pipeline.
//
//   channel | handshake           | payload
//   --------+---------------------+---------------------------------------------
//   in      | in_valid / in_ready | positions, velocities, masses, radius, dist
//   out     | out_valid/out_ready | new velocities, hit, degenerate
//
// One beat per cycle sustained while out_ready stays high; six arithmetic stages, one
// stage per quotient bit of the 26-bit restoring divider, and the output register.
// Reset clears only the stage valid bits; no clearing pass.
// Each stage holds when it is full and the stage after it holds, so bubbles
// collapse and a stalled output does not block input until the pipe is full.
module elastic_circle_collision_response_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] pos_i_x,
  input  logic signed [23:0] pos_i_y,
  input  logic signed [23:0] pos_j_x,
  input  logic signed [23:0] pos_j_y,
  input  logic signed [23:0] vel_i_x,
  input  logic signed [23:0] vel_i_y,
  input  logic signed [23:0] vel_j_x,
  input  logic signed [23:0] vel_j_y,
  input  logic [15:0]        mass_i,
  input  logic [15:0]        mass_j,
  input  logic [23:0]        radius_sum,
  input  logic [23:0]        centre_distance,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] new_vel_i_x,
  output logic signed [23:0] new_vel_i_y,
  output logic signed [23:0] new_vel_j_x,
  output logic signed [23:0] new_vel_j_y,
  output logic               hit,
  output logic               degenerate
);
  import ecc_pkg::*;

  logic [NumStages-1:0] v;
  logic [NumStages-1:0] en;
  side_t                side [OutStage];

  // stage enables: a stage advances when empty or when its successor advances
  always_comb begin
    en[NumStages-1] = ~v[NumStages-1] | out_ready;
    for (int k = NumStages-2; k >= 0; k--) begin
      en[k] = ~v[k] | en[k+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 0: differences and mass terms
  logic signed [24:0] s0_dx, s0_dy, s0_dvx, s0_dvy;
  logic [16:0]        s0_msum, s0_m2i, s0_m2j;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_dx   <= $signed({pos_j_x[23], pos_j_x}) - $signed({pos_i_x[23], pos_i_x});
      s0_dy   <= $signed({pos_j_y[23], pos_j_y}) - $signed({pos_i_y[23], pos_i_y});
      s0_dvx  <= $signed({vel_j_x[23], vel_j_x}) - $signed({vel_i_x[23], vel_i_x});
      s0_dvy  <= $signed({vel_j_y[23], vel_j_y}) - $signed({vel_i_y[23], vel_i_y});
      s0_msum <= {1'b0, mass_i} + {1'b0, mass_j};
      s0_m2i  <= {mass_i, 1'b0};
      s0_m2j  <= {mass_j, 1'b0};
      side[0] <= '{vel_i_x: vel_i_x, vel_i_y: vel_i_y, vel_j_x: vel_j_x,
                   vel_j_y: vel_j_y, touch: (centre_distance <= radius_sum),
                   default: 1'b0};
    end
  end

  // stage 1: products
  logic signed [49:0] s1_pdx, s1_pdy, s1_sqx, s1_sqy;
  logic signed [24:0] s1_dx, s1_dy;
  logic [16:0]        s1_msum, s1_m2i, s1_m2j;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_pdx  <= s0_dvx * s0_dx;
      s1_pdy  <= s0_dvy * s0_dy;
      s1_sqx  <= s0_dx * s0_dx;
      s1_sqy  <= s0_dy * s0_dy;
      s1_dx   <= s0_dx;
      s1_dy   <= s0_dy;
      s1_msum <= s0_msum;
      s1_m2i  <= s0_m2i;
      s1_m2j  <= s0_m2j;
      side[1] <= side[0];
    end
  end

  // stage 2: dot product, squared length, magnitudes
  logic signed [50:0] s2_dot;
  logic [48:0]        s2_dd;
  logic [23:0]        s2_adx, s2_ady;
  logic               s2_ndx, s2_ndy;
  logic [16:0]        s2_msum, s2_m2i, s2_m2j;
  logic signed [24:0] neg_dx, neg_dy;

  assign neg_dx = -s1_dx;
  assign neg_dy = -s1_dy;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_dot  <= $signed({s1_pdx[49], s1_pdx}) + $signed({s1_pdy[49], s1_pdy});
      s2_dd   <= {1'b0, s1_sqx[47:0]} + {1'b0, s1_sqy[47:0]};
      s2_adx  <= s1_dx[24] ? neg_dx[23:0] : s1_dx[23:0];
      s2_ady  <= s1_dy[24] ? neg_dy[23:0] : s1_dy[23:0];
      s2_ndx  <= s1_dx[24];
      s2_ndy  <= s1_dy[24];
      s2_msum <= s1_msum;
      s2_m2i  <= s1_m2i;
      s2_m2j  <= s1_m2j;
      side[2] <= side[1];
    end
  end

  // stage 3: divisor, per-lane scale factors, flags
  logic [DenW-1:0]    s3_den;
  logic [40:0]        s3_k [Lanes];
  logic [48:0]        s3_adot;
  logic signed [50:0] neg_dot;
  side_t              side3;

  assign neg_dot = -s2_dot;

  always_comb begin
    side3       = side[2];
    side3.hit   = side[2].touch & (s2_dd != '0);
    side3.degen = side[2].touch & (s2_dd == '0);
    side3.apply = side[2].touch & (s2_dd != '0) & (s2_msum != '0);
    side3.neg_x = s2_dot[50] ^ s2_ndx;
    side3.neg_y = s2_dot[50] ^ s2_ndy;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_den  <= s2_dd * s2_msum;
      s3_k[0] <= s2_adx * s2_m2j;
      s3_k[1] <= s2_ady * s2_m2j;
      s3_k[2] <= s2_adx * s2_m2i;
      s3_k[3] <= s2_ady * s2_m2i;
      s3_adot <= s2_dot[50] ? neg_dot[48:0] : s2_dot[48:0];
      side[3] <= side3;
    end
  end

  // stage 4: split products of |dot| and the scale factors
  logic [65:0]     s4_plo [Lanes];
  logic [64:0]     s4_phi [Lanes];
  logic [DenW-1:0] s4_den;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int l = 0; l < Lanes; l++) begin
        s4_plo[l] <= s3_adot[24:0] * s3_k[l];
        s4_phi[l] <= s3_adot[48:25] * s3_k[l];
      end
      s4_den  <= s3_den;
      side[4] <= side[3];
    end
  end

  // stage 5: numerators
  logic [NumW-1:0] s5_num [Lanes];
  logic [DenW-1:0] s5_den;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int l = 0; l < Lanes; l++) begin
        s5_num[l] <= {s4_phi[l], 25'b0} + NumW'(s4_plo[l]);
      end
      s5_den  <= s4_den;
      side[5] <= side[4];
    end
  end

  // divider stages
  logic [QuoW-1:0] quo [Lanes];

  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    ecc_divider u_div (
      .clk    (clk),
      .en     (en[DivFirst +: QuoW]),
      .num_in (s5_num[l]),
      .den_in (s5_den),
      .quo    (quo[l])
    );
  end

  for (genvar k = DivFirst; k < OutStage; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[k]) side[k] <= side[k-1];
    end
  end

  // output stage: signed update with saturation
  function automatic logic signed [VelW-1:0] sat_add(
    input logic signed [VelW-1:0] vel,
    input logic [QuoW-1:0]        q,
    input logic                   neg,
    input logic                   apply
  );
    logic signed [QuoW+1:0] mag;
    logic signed [QuoW+1:0] delta;
    logic signed [QuoW+1:0] sum;
    mag   = $signed({2'b00, q});
    delta = apply ? (neg ? -mag : mag) : '0;
    sum   = $signed({{(QuoW+2-VelW){vel[VelW-1]}}, vel}) + delta;
    if (sum > $signed((QuoW+2)'(8388607))) begin
      sat_add = 24'sh7FFFFF;
    end else if (sum < -$signed((QuoW+2)'(8388608))) begin
      sat_add = 24'sh800000;
    end else begin
      sat_add = sum[VelW-1:0];
    end
  endfunction

  side_t last;
  assign last = side[OutStage-1];

  always_ff @(posedge clk) begin
    if (en[OutStage]) begin
      new_vel_i_x <= sat_add(last.vel_i_x, quo[0], last.neg_x, last.apply);
      new_vel_i_y <= sat_add(last.vel_i_y, quo[1], last.neg_y, last.apply);
      new_vel_j_x <= sat_add(last.vel_j_x, quo[2], ~last.neg_x, last.apply);
      new_vel_j_y <= sat_add(last.vel_j_y, quo[3], ~last.neg_y, last.apply);
      hit         <= last.hit;
      degenerate  <= last.degen;
    end
  end

  assign out_valid = v[OutStage];

endmodule

>>> hdl/ecc_divider.sv
// One lane of the pipelined restoring divider, one quotient bit per stage.
module ecc_divider (
  input  logic                       clk,
  input  logic [ecc_pkg::QuoW-1:0]   en,
  input  logic [ecc_pkg::NumW-1:0]   num_in,
  input  logic [ecc_pkg::DenW-1:0]   den_in,
  output logic [ecc_pkg::QuoW-1:0]   quo
);
  import ecc_pkg::*;

  logic [DenW-1:0] rem  [QuoW];
  logic [DenW-1:0] dreg [QuoW];
  logic [QuoW-1:0] low  [QuoW];
  logic [QuoW-1:0] qreg [QuoW];

  for (genvar j = 0; j < QuoW; j++) begin : g_step
    logic [DenW-1:0] prev_rem;
    logic [DenW-1:0] prev_den;
    logic [QuoW-1:0] prev_low;
    logic [QuoW-1:0] prev_q;
    logic [DenW:0]   trial;
    logic [DenW+1:0] diff;
    logic            ge;

    if (j == 0) begin : g_first
      assign prev_rem = DenW'(num_in[NumW-1:QuoW]);
      assign prev_den = den_in;
      assign prev_low = num_in[QuoW-1:0];
      assign prev_q   = '0;
    end else begin : g_rest
      assign prev_rem = rem[j-1];
      assign prev_den = dreg[j-1];
      assign prev_low = low[j-1];
      assign prev_q   = qreg[j-1];
    end

    assign trial = {prev_rem, prev_low[QuoW-1]};
    assign diff  = {1'b0, trial} - {2'b00, prev_den};
    assign ge    = ~diff[DenW+1];

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem[j]  <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
        dreg[j] <= prev_den;
        low[j]  <= {prev_low[QuoW-2:0], 1'b0};
        qreg[j] <= {prev_q[QuoW-2:0], ge};
      end
    end
  end

  assign quo = qreg[QuoW-1];

endmodule

>>> hdl/ecc_checker.sv
// Port-level checker of the collision unit and its bind.
`include "elastic_circle_collision_response_unit_macros.svh"

module ecc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [23:0] new_vel_i_x,
  input logic               hit,
  input logic               degenerate
);

  `ECC_ASSERT_NEXT(a_reset_empty, rst, !out_valid)
  `ECC_ASSERT_IMPL(a_flags_exclusive, out_valid, !(hit && degenerate))
  `ECC_ASSERT_IMPL(a_empty_out_takes_input, !out_valid, in_ready)
  `ECC_ASSERT_IMPL(a_stall_holds, out_valid && !out_ready && !rst, ##1 ($stable(new_vel_i_x) && $stable(hit)))

endmodule

bind elastic_circle_collision_response_unit ecc_checker u_ecc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .new_vel_i_x (new_vel_i_x),
  .hit         (hit),
  .degenerate  (degenerate)
);

>>> verif/testbench.sv
// Self-checking testbench for the elastic circle collision velocity update unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomItems = 1240;
  localparam int QuietItems  = 150;
  localparam int StallLimit  = 3000;
  localparam int Latency     = 33;
  localparam logic signed [23:0] VelMax = 24'sh7FFFFF;
  localparam logic signed [23:0] VelMin = 24'sh800000;

  typedef struct packed {
    logic signed [23:0] pix, piy, pjx, pjy;
    logic signed [23:0] vix, viy, vjx, vjy;
    logic [15:0]        mi, mj;
    logic [23:0]        rsum, cdist;
  } pair_t;

  typedef struct packed {
    logic signed [23:0] vix, viy, vjx, vjy;
    logic               hit;
    logic               degen;
  } bounce_t;

  function automatic logic signed [23:0] clamp24(longint x);
    if (x > longint'(VelMax)) return VelMax;
    if (x < longint'(VelMin)) return VelMin;
    return x[23:0];
  endfunction

  // Exact integer form of the elastic rule, quotients truncated toward zero.
  function automatic bounce_t predict_bounce(pair_t p);
    bounce_t r;
    longint d[2], vel[4], dot, dk, adot, ad;
    longint unsigned dd, msum;
    logic [127:0] base, den, qi, qj;
    logic neg;
    vel[0] = p.vix; vel[1] = p.viy; vel[2] = p.vjx; vel[3] = p.vjy;
    r.hit = 0;
    r.degen = 0;
    if (p.cdist <= p.rsum) begin
      d[0] = longint'(p.pjx) - longint'(p.pix);
      d[1] = longint'(p.pjy) - longint'(p.piy);
      dot = (vel[2] - vel[0]) * d[0] + (vel[3] - vel[1]) * d[1];
      dd = d[0] * d[0] + d[1] * d[1];
      msum = longint'(p.mi) + longint'(p.mj);
      if (dd == 0) begin
        r.degen = 1;
      end else begin
        r.hit = 1;
        if (msum != 0) begin
          den = 128'(dd) * 128'(msum);
          adot = dot < 0 ? -dot : dot;
          for (int k = 0; k < 2; k++) begin
            dk = d[k];
            ad = dk < 0 ? -dk : dk;
            base = 128'(adot) * 128'(ad);
            qi = (base * 128'(2 * longint'(p.mj))) / den;
            qj = (base * 128'(2 * longint'(p.mi))) / den;
            neg = (dot < 0) != (dk < 0);
            vel[k]     = clamp24(vel[k] + (neg ? -longint'(qi[63:0]) : longint'(qi[63:0])));
            vel[2 + k] = clamp24(vel[2 + k] - (neg ? -longint'(qj[63:0]) : longint'(qj[63:0])));
          end
        end
      end
    end
    r.vix = vel[0][23:0]; r.viy = vel[1][23:0];
    r.vjx = vel[2][23:0]; r.vjy = vel[3][23:0];
    return r;
  endfunction

  class bounce_scoreboard;
    bounce_t pending_bounces[$];
    int errors = 0;

    function void note_pair(pair_t p);
      pending_bounces = {pending_bounces, predict_bounce(p)};
    endfunction

    function void check_bounce(bounce_t got);
      bounce_t want;
      if (pending_bounces.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
        return;
      end
      want = pending_bounces.pop_front();
      if (got.vix !== want.vix) begin
        $display("%0t: new_vel_i_x expected %0d actual %0d", $time, want.vix, got.vix);
        errors++;
      end
      if (got.viy !== want.viy) begin
        $display("%0t: new_vel_i_y expected %0d actual %0d", $time, want.viy, got.viy);
        errors++;
      end
      if (got.vjx !== want.vjx) begin
        $display("%0t: new_vel_j_x expected %0d actual %0d", $time, want.vjx, got.vjx);
        errors++;
      end
      if (got.vjy !== want.vjy) begin
        $display("%0t: new_vel_j_y expected %0d actual %0d", $time, want.vjy, got.vjy);
        errors++;
      end
      if (got.hit !== want.hit) begin
        $display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
        errors++;
      end
      if (got.degen !== want.degen) begin
        $display("%0t: degenerate expected %0b actual %0b", $time, want.degen, got.degen);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic out_ready = 0;
  pair_t drv = '0;
  logic in_ready, out_valid, hit, degenerate;
  logic signed [23:0] new_vel_i_x, new_vel_i_y, new_vel_j_x, new_vel_j_y;
  bit quiet = 0;
  int idle_cycles = 0;
  bounce_scoreboard sb = new();

  always #10 clk = ~clk;

  elastic_circle_collision_response_unit dut (
    .clk, .rst, .in_valid, .in_ready,
    .pos_i_x(drv.pix), .pos_i_y(drv.piy), .pos_j_x(drv.pjx), .pos_j_y(drv.pjy),
    .vel_i_x(drv.vix), .vel_i_y(drv.viy), .vel_j_x(drv.vjx), .vel_j_y(drv.vjy),
    .mass_i(drv.mi), .mass_j(drv.mj), .radius_sum(drv.rsum), .centre_distance(drv.cdist),
    .out_valid, .out_ready,
    .new_vel_i_x, .new_vel_i_y, .new_vel_j_x, .new_vel_j_y, .hit, .degenerate
  );

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_pair(drv);
    if (!rst && out_valid && out_ready)
      sb.check_bounce({new_vel_i_x, new_vel_i_y, new_vel_j_x, new_vel_j_y, hit, degenerate});
  end

  // Receiver stalls in bursts of random length.
  int stall_left = 0;
  always @(posedge clk) begin
    if (quiet || rst) begin
      out_ready <= 1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_pair(pair_t p);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    drv <= p;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain;
    in_valid <= 0;
    do @(posedge clk); while (sb.pending_bounces.size() != 0);
  endtask

  function automatic logic [23:0] pick24();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'(int'($urandom_range(0, 8191)) - 4096);
      3: return 24'(int'($urandom_range(0, 1023)) - 512);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    p.pix = pick24(); p.piy = pick24();
    case ($urandom_range(0, 9))
      0: begin p.pjx = p.pix; p.pjy = p.piy; end
      1, 2: begin p.pjx = pick24(); p.pjy = pick24(); end
      default: begin
        p.pjx = p.pix + 24'(int'($urandom_range(0, 4095)) - 2048);
        p.pjy = p.piy + 24'(int'($urandom_range(0, 4095)) - 2048);
      end
    endcase
    p.vix = pick24(); p.viy = pick24(); p.vjx = pick24(); p.vjy = pick24();
    p.mi = ($urandom_range(0, 9) == 0) ? 16'h0 : 16'($urandom);
    p.mj = ($urandom_range(0, 9) == 0) ? 16'h0 : 16'($urandom);
    p.rsum = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 65535));
    if ($urandom_range(0, 3) != 0)
      p.cdist = 24'($urandom_range(0, int'(p.rsum)));
    else
      p.cdist = 24'($urandom);
    return p;
  endfunction

  initial begin
    pair_t p;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: apart, coincident, zero masses, full-scale saturation, extremes.
    p = '{pix: 0, piy: 0, pjx: 24'sd512, pjy: 0, vix: 24'sd256, viy: 0,
          vjx: -24'sd256, vjy: 0, mi: 16'd256, mj: 16'd256, rsum: 24'd256, cdist: 24'd512};
    send_pair(p);
    p.cdist = 24'd256; p.rsum = 24'd512;
    send_pair(p);
    p.mi = 16'd0; p.mj = 16'd0;
    send_pair(p);
    p.mi = 16'hFFFF; p.mj = 16'd0;
    send_pair(p);
    p.mi = 16'd0; p.mj = 16'hFFFF;
    send_pair(p);
    p.pjx = p.pix;
    send_pair(p);
    p = '{pix: VelMin, piy: VelMin, pjx: VelMax, pjy: VelMax, vix: VelMax, viy: VelMax,
          vjx: VelMin, vjy: VelMin, mi: 16'hFFFF, mj: 16'hFFFF, rsum: 24'hFFFFFF, cdist: 24'hFFFFFF};
    send_pair(p);
    p.vix = VelMin; p.viy = VelMin; p.vjx = VelMax; p.vjy = VelMax;
    send_pair(p);
    p.pjx = VelMin; p.pjy = VelMax; p.pix = VelMax; p.piy = VelMin;
    send_pair(p);
    p.mi = 16'd1; p.mj = 16'hFFFF;
    send_pair(p);
    p.cdist = 24'd0; p.rsum = 24'd0;
    send_pair(p);
    p.cdist = 24'd1;
    send_pair(p);
    p = '{pix: 24'sd100, piy: -24'sd300, pjx: 24'sd101, pjy: -24'sd300, vix: -24'sd7,
          viy: 24'sd3, vjx: 24'sd5, vjy: -24'sd9, mi: 16'd1, mj: 16'd1, rsum: 24'd9, cdist: 24'd9};
    send_pair(p);
    p.pjy = -24'sd301; p.mi = 16'd3; p.mj = 16'd7;
    send_pair(p);
    drain();

    for (int n = 0; n < RandomItems; n++) begin
      if (n == RandomItems - QuietItems) quiet = 1;
      if (n == RandomItems / 2) drain();
      send_pair(random_pair());
    end
    in_valid <= 0;

    while (sb.pending_bounces.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending_bounces.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+hdl
hdl/ecc_pkg.sv
hdl/ecc_divider.sv
hdl/elastic_circle_collision_response_unit.sv
hdl/ecc_checker.sv
verif/testbench.sv
